@@ sv/elp_pkg.sv @@
package elp_pkg;

  // Fixed field widths.
  localparam int TimeW   = 32;
  localparam int ValueW  = 16;
  localparam int IndexW  = 4;
  localparam int ShiftW  = 5;
  localparam int FracW   = 5;
  localparam int WholeW  = 4;

  // Ticks above this limit mean the supplied time is behind the stored time.
  localparam logic [TimeW-1:0] BehindLimit = 32'hFFFF_FC00;
  // Ticks at or above 2^ClearShift clear every counter.
  localparam int ClearShift = 9;
  // A half-life spans 2^HalfLifeLog ticks.
  localparam int HalfLifeLog = 5;

  // Command codes.
  localparam logic CmdAdvance = 1'b0;
  localparam logic CmdWrite   = 1'b1;

  // What the decay unit does to a counter during one advance.
  typedef enum logic [1:0] {
    DECAY_KEEP  = 2'b00,
    DECAY_CLEAR = 2'b01,
    DECAY_SCALE = 2'b10
  } decay_mode_t;

  // Control from the sequencer to the shared decay unit.
  typedef struct packed {
    decay_mode_t       mode;
    logic [FracW-1:0]  frac;
    logic [WholeW-1:0] whole;
  } decay_ctrl_t;

  // Factor round(2^16 * 0.5^(f/32)); a fraction of zero is handled as a factor of one.
  function automatic logic [ValueW-1:0] frac_factor(input logic [FracW-1:0] f);
    logic [ValueW-1:0] r;
    r = '0;
    case (f)
      5'd0:  r = 16'd0;
      5'd1:  r = 16'd64132;
      5'd2:  r = 16'd62757;
      5'd3:  r = 16'd61413;
      5'd4:  r = 16'd60097;
      5'd5:  r = 16'd58809;
      5'd6:  r = 16'd57549;
      5'd7:  r = 16'd56316;
      5'd8:  r = 16'd55109;
      5'd9:  r = 16'd53928;
      5'd10: r = 16'd52773;
      5'd11: r = 16'd51642;
      5'd12: r = 16'd50535;
      5'd13: r = 16'd49452;
      5'd14: r = 16'd48393;
      5'd15: r = 16'd47356;
      5'd16: r = 16'd46341;
      5'd17: r = 16'd45348;
      5'd18: r = 16'd44376;
      5'd19: r = 16'd43425;
      5'd20: r = 16'd42495;
      5'd21: r = 16'd41584;
      5'd22: r = 16'd40693;
      5'd23: r = 16'd39821;
      5'd24: r = 16'd38968;
      5'd25: r = 16'd38133;
      5'd26: r = 16'd37316;
      5'd27: r = 16'd36516;
      5'd28: r = 16'd35734;
      5'd29: r = 16'd34968;
      5'd30: r = 16'd34219;
      5'd31: r = 16'd33486;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/exponential_load_decay.sv @@
// Bank of LOAD_COUNT 16-bit load counters that decay exponentially with a half-life of
// 32 ticks. A write transaction (cmd 1) sets one counter and returns one result in the
// cycle after it is accepted; the next transaction can be taken in the following cycle,
// unless the output stalls. An advance transaction (cmd 0) is accepted, then works out
// the elapsed ticks and updates the stored time, then takes one step per counter as the
// ring of counter cells rotates through the single shared multiplier, emitting counters
// in ascending index order. Output stall holds the rotation in place. The configuration
// port writes tick_len_log and is always ready; write it only while the block is idle.
module exponential_load_decay #(
  parameter int LOAD_COUNT = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [elp_pkg::ShiftW-1:0]  tick_len_log,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [elp_pkg::TimeW-1:0]   present_time,
  input  logic [elp_pkg::IndexW-1:0]  write_index,
  input  logic [elp_pkg::ValueW-1:0]  write_value,
  // Output channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [elp_pkg::IndexW-1:0]  load_index,
  output logic [elp_pkg::ValueW-1:0]  load_value,
  output logic                        time_taken,
  output logic                        last
);
  import elp_pkg::*;

  localparam int CntW = (LOAD_COUNT > 1) ? $clog2(LOAD_COUNT) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(LOAD_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t             state;
  logic [ShiftW-1:0]  tick_shift;
  logic [TimeW-1:0]   last_time;
  logic [TimeW-1:0]   now_q;
  decay_ctrl_t        ctrl;
  logic               taken_q;
  logic [CntW-1:0]    idx;

  logic               in_acc;
  logic               wr_acc;
  logic               out_free;
  logic               step;
  logic [TimeW-1:0]   ticks;
  logic               ticks_ok;
  logic               in_range;
  logic [ValueW-1:0]  head_decayed;

  logic [ValueW-1:0]  cell_val [LOAD_COUNT];
  logic [LOAD_COUNT-1:0] cell_wr;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign wr_acc    = in_acc && (cmd == CmdWrite);
  assign step      = (state == ST_RUN) && out_free;
  assign in_range  = ({28'd0, write_index} < 32'(LOAD_COUNT));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_shift <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tick_shift <= tick_len_log;
    end
  end

  // Elapsed ticks since the stored time, with 32-bit wrap.
  assign ticks    = (now_q - last_time) >> tick_shift;
  assign ticks_ok = (ticks != '0) && (ticks <= BehindLimit);

  // Sequencer: accept, set up the decay, then rotate the ring once.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_time <= '0;
      idx       <= '0;
      taken_q   <= 1'b0;
      ctrl      <= '{mode: DECAY_KEEP, frac: '0, whole: '0};
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && (cmd == CmdAdvance)) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          idx     <= '0;
          taken_q <= ticks_ok;
          ctrl.frac  <= ticks[FracW-1:0];
          ctrl.whole <= ticks[HalfLifeLog +: WholeW];
          if (!ticks_ok) begin
            ctrl.mode <= DECAY_KEEP;
          end else if (ticks[TimeW-1:ClearShift] != '0) begin
            ctrl.mode <= DECAY_CLEAR;
          end else begin
            ctrl.mode <= DECAY_SCALE;
          end
          if (ticks_ok) begin
            last_time <= now_q;
          end
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (step) begin
            idx <= idx + 1'b1;
            if (idx == LastIdx) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture the time of every accepted transaction; only an advance makes use of it.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_q <= present_time;
    end
  end

  // Shared decay unit on the head of the ring.
  elp_decay u_decay (
    .ctrl      (ctrl),
    .value_in  (cell_val[0]),
    .value_out (head_decayed)
  );

  // Ring of counter cells; each step moves every counter one place toward the head,
  // and the decayed head re-enters at the tail.
  genvar g;
  generate
    for (g = 0; g < LOAD_COUNT; g++) begin : g_cell
      assign cell_wr[g] = wr_acc && ({28'd0, write_index} == 32'(g));
      if (g == LOAD_COUNT - 1) begin : g_tail
        elp_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (step),
          .shift_in (head_decayed),
          .wr_en    (cell_wr[g]),
          .wr_data  (write_value),
          .value    (cell_val[g])
        );
      end else begin : g_body
        elp_cell u_cell (
          .clk      (clk),
          .rst      (rst),
          .shift_en (step),
          .shift_in (cell_val[g+1]),
          .wr_en    (cell_wr[g]),
          .wr_data  (write_value),
          .value    (cell_val[g])
        );
      end
    end
  endgenerate

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_acc || step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (wr_acc) begin
      load_index <= write_index;
      load_value <= in_range ? write_value : '0;
      time_taken <= 1'b0;
      last       <= 1'b1;
    end else if (step) begin
      load_index <= IndexW'(idx);
      load_value <= head_decayed;
      time_taken <= taken_q;
      last       <= (idx == LastIdx);
    end
  end

  // An accepted advance always moves on to the setup cycle.
  a_advance_calc: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (cmd == CmdAdvance)) |=> (state == ST_CALC))
    else $error("advance did not enter setup");

  // The stored time follows a valid advance.
  a_time_update: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CALC) && ticks_ok) |=> (last_time == $past(now_q)))
    else $error("stored time not updated");

  // The final counter of a rotation ends the run.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (step && (idx == LastIdx)) |=> (state == ST_IDLE) && out_valid && last)
    else $error("run did not end on the final counter");

  // A result that is not the final one comes only from a running rotation.
  a_mid_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (state == ST_RUN))
    else $error("intermediate result outside a rotation");

endmodule

@@ sv/elp_cell.sv @@
module elp_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift_en,
  input  logic [elp_pkg::ValueW-1:0] shift_in,
  input  logic                       wr_en,
  input  logic [elp_pkg::ValueW-1:0] wr_data,
  output logic [elp_pkg::ValueW-1:0] value
);
  import elp_pkg::*;

  // One load counter; it either takes a direct write or the value of its neighbor.
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (wr_en) begin
      value <= wr_data;
    end else if (shift_en) begin
      value <= shift_in;
    end
  end

endmodule

@@ sv/elp_decay.sv @@
module elp_decay (
  input  elp_pkg::decay_ctrl_t       ctrl,
  input  logic [elp_pkg::ValueW-1:0] value_in,
  output logic [elp_pkg::ValueW-1:0] value_out
);
  import elp_pkg::*;

  logic [2*ValueW-1:0] product;
  logic [ValueW:0]     rounded;
  logic [ValueW:0]     scaled;
  logic [ValueW:0]     shifted;

  // Multiply by the fractional factor and round half up on bit 15.
  assign product = (2*ValueW)'(value_in) * (2*ValueW)'(frac_factor(ctrl.frac));
  assign rounded = (ValueW+1)'(product[2*ValueW-1:ValueW]) +
                   (ValueW+1)'(product[ValueW-1]);

  // A zero fraction means a factor of one, so only the whole halvings apply.
  assign scaled  = (ctrl.frac == '0) ? {1'b0, value_in} : rounded;
  assign shifted = scaled >> ctrl.whole;

  // Select the result for this advance.
  always_comb begin
    case (ctrl.mode)
      DECAY_KEEP:  value_out = value_in;
      DECAY_CLEAR: value_out = '0;
      DECAY_SCALE: value_out = shifted[ValueW-1:0];
      default:     value_out = value_in;
    endcase
  end

endmodule

@@ tb/exponential_load_decay_tb.sv @@
`timescale 1ns / 1ps

module exponential_load_decay_tb;
  import elp_pkg::*;

  localparam int LoadCount = 15;
  localparam int SideSend = 0;
  localparam int SideRecv = 1;

  // Half-life-32 factors, round(2^16 * 0.5^(f/32)); entry zero is never used.
  localparam logic [ValueW-1:0] DecayFactor [32] = '{
    16'd0,     16'd64132, 16'd62757, 16'd61413, 16'd60097, 16'd58809, 16'd57549, 16'd56316,
    16'd55109, 16'd53928, 16'd52773, 16'd51642, 16'd50535, 16'd49452, 16'd48393, 16'd47356,
    16'd46341, 16'd45348, 16'd44376, 16'd43425, 16'd42495, 16'd41584, 16'd40693, 16'd39821,
    16'd38968, 16'd38133, 16'd37316, 16'd36516, 16'd35734, 16'd34968, 16'd34219, 16'd33486
  };

  // One reported counter.
  typedef struct {
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
    logic              taken;
    logic              is_last;
  } load_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ShiftW-1:0] tick_len_log = '0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              cmd = CmdAdvance;
  logic [TimeW-1:0]  present_time = '0;
  logic [IndexW-1:0] write_index = '0;
  logic [ValueW-1:0] write_value = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IndexW-1:0] load_index;
  logic [ValueW-1:0] load_value;
  logic              time_taken;
  logic              last;

  // Predicted state of the counter bank.
  logic [ValueW-1:0] bank_model [LoadCount];
  logic [TimeW-1:0]  stored_time_model = '0;
  logic [ShiftW-1:0] tick_shift = '0;

  load_report_t pending_reports [$];

  int fail_count = 0;
  int write_count = 0;
  int advance_count = 0;
  int taken_count = 0;
  int clear_count = 0;
  int reports_checked = 0;
  int cfg_count = 0;
  int calm_run [2] = '{0, 0};
  int in_gap = 0;
  bit in_held = 1'b0;
  int out_wait = 0;

  exponential_load_decay #(
    .LOAD_COUNT(LoadCount)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .tick_len_log(tick_len_log),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .present_time(present_time),
    .write_index(write_index),
    .write_value(write_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .load_index(load_index),
    .load_value(load_value),
    .time_taken(time_taken),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    foreach (bank_model[i]) bank_model[i] = '0;
  end

  // Idle cycles before the next transaction on one side, with calm runs of no idling.
  function automatic int draw_wait(input int side);
    if (calm_run[side] > 0) begin
      calm_run[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_run[side] = $urandom_range(8, 30);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) begin
      return $urandom_range(0, 2);
    end
    return $urandom_range(0, 19);
  endfunction

  // One counter after a decay by the fractional step and the whole half-lives.
  function automatic logic [ValueW-1:0] decayed(input logic [ValueW-1:0] v,
                                                input logic [FracW-1:0] frac,
                                                input logic [WholeW-1:0] whole);
    logic [31:0] prod;
    logic [16:0] rounded;
    if (frac == '0) begin
      rounded = {1'b0, v};
    end else begin
      prod = 32'(v) * 32'(DecayFactor[frac]);
      rounded = {1'b0, prod[31:16]} + 17'(prod[15]);
    end
    return ValueW'(rounded >> whole);
  endfunction

  task automatic push_report(input logic [IndexW-1:0] idx, input logic [ValueW-1:0] val,
                             input logic taken, input logic is_last);
    load_report_t r;
    r.index = idx;
    r.value = val;
    r.taken = taken;
    r.is_last = is_last;
    pending_reports.push_back(r);
  endtask

  // Update the predicted bank for one accepted transaction and queue its reports.
  task automatic predict_loads(input logic c, input logic [TimeW-1:0] t,
                               input logic [IndexW-1:0] wi, input logic [ValueW-1:0] wv);
    logic [TimeW-1:0] ticks;
    decay_mode_t mode;
    logic taken;
    if (c == CmdWrite) begin
      write_count++;
      if (wi < LoadCount) begin
        bank_model[wi] = wv;
        push_report(wi, wv, 1'b0, 1'b1);
      end else begin
        push_report(wi, '0, 1'b0, 1'b1);
      end
    end else begin
      advance_count++;
      ticks = (t - stored_time_model) >> tick_shift;
      if (ticks == '0 || ticks > BehindLimit) begin
        mode = DECAY_KEEP;
      end else if ((ticks >> ClearShift) != '0) begin
        mode = DECAY_CLEAR;
      end else begin
        mode = DECAY_SCALE;
      end
      taken = (mode != DECAY_KEEP);
      if (taken) begin
        stored_time_model = t;
        taken_count++;
      end
      if (mode == DECAY_CLEAR) clear_count++;
      for (int i = 0; i < LoadCount; i++) begin
        if (mode == DECAY_CLEAR) begin
          bank_model[i] = '0;
        end else if (mode == DECAY_SCALE) begin
          bank_model[i] = decayed(bank_model[i], ticks[FracW-1:0],
                                  ticks[HalfLifeLog+WholeW-1:HalfLifeLog]);
        end
        push_report(IndexW'(i), bank_model[i], taken, i == LoadCount - 1);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Send one transaction; valid stays high only when the next one follows at once.
  task automatic send_item(input logic c, input logic [TimeW-1:0] t,
                           input logic [IndexW-1:0] wi, input logic [ValueW-1:0] wv);
    if (!in_held) begin
      repeat (in_gap) @(posedge clk);
    end
    cmd <= c;
    present_time <= t;
    write_index <= wi;
    write_value <= wv;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_loads(c, t, wi, wv);
    in_gap = draw_wait(SideSend);
    in_held = (in_gap == 0);
    if (!in_held) in_valid <= 1'b0;
  endtask

  task automatic send_write(input logic [IndexW-1:0] wi, input logic [ValueW-1:0] wv);
    send_item(CmdWrite, $urandom, wi, wv);
  endtask

  task automatic send_advance(input logic [TimeW-1:0] t);
    send_item(CmdAdvance, t, IndexW'($urandom), ValueW'($urandom));
  endtask

  // Time that lies the given number of ticks past the stored time, with random low bits.
  function automatic logic [TimeW-1:0] time_after(input int unsigned ticks);
    logic [63:0] delta;
    logic [63:0] low_mask;
    low_mask = (64'd1 << tick_shift) - 64'd1;
    delta = (64'(ticks) << tick_shift) | (64'($urandom) & low_mask);
    return stored_time_model + delta[TimeW-1:0];
  endfunction

  // Stop sending and wait until every queued report has come back.
  task automatic drain_reports();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
    end
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_tick_len(input logic [ShiftW-1:0] v);
    cfg_valid <= 1'b1;
    tick_len_log <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tick_shift = v;
    cfg_count++;
  endtask

  // Receiving side: check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    load_report_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        reports_checked++;
        if (pending_reports.size() == 0) begin
          report_mismatch("result with nothing expected, value", int'(load_value), 0);
        end else begin
          want = pending_reports.pop_front();
          if (load_index !== want.index)
            report_mismatch("load_index", int'(load_index), int'(want.index));
          if (load_value !== want.value)
            report_mismatch("load_value", int'(load_value), int'(want.value));
          if (time_taken !== want.taken)
            report_mismatch("time_taken", int'(time_taken), int'(want.taken));
          if (last !== want.is_last)
            report_mismatch("last", int'(last), int'(want.is_last));
        end
        out_wait = draw_wait(SideRecv);
      end else if (out_wait != 0) begin
        out_wait--;
      end
      out_stall <= (out_wait != 0);
    end
  end

  // Counter writes across the bank, the value extremes and an index past the end.
  task automatic test_writes();
    write_tick_len(5'd0);
    send_write(4'd0, 16'hFFFF);
    send_write(4'd14, 16'h0001);
    send_write(4'd7, 16'h8000);
    send_write(4'd15, 16'hABCD);
    send_write(4'd3, 16'h0000);
    send_write(4'd9, 16'h1234);
    drain_reports();
  endtask

  // Each decay case: no ticks, one tick, whole half-lives, the longest decay, clearing,
  // time behind, and the edge of the behind limit.
  task automatic test_decay_cases();
    send_advance(stored_time_model);
    send_advance(stored_time_model + 32'd1);
    send_advance(stored_time_model + 32'd32);
    send_advance(stored_time_model + 32'd31);
    send_write(4'd0, 16'hFFFF);
    send_write(4'd14, 16'hFFFF);
    send_advance(stored_time_model + 32'd511);
    send_write(4'd0, 16'hFFFF);
    send_advance(stored_time_model + 32'd512);
    send_advance(stored_time_model - 32'd1);
    send_write(4'd5, 16'hFFFF);
    send_advance(stored_time_model - 32'd1024);
    send_write(4'd5, 16'hFFFF);
    send_advance(stored_time_model - 32'd1023);
    send_advance(32'hFFFF_FFFF);
    drain_reports();
  endtask

  // The longest and a middle tick length.
  task automatic test_tick_length();
    write_tick_len(5'd31);
    send_write(4'd2, 16'hFFFF);
    send_advance(stored_time_model + 32'h7FFF_FFFF);
    send_advance(stored_time_model + 32'h8000_0000);
    drain_reports();
    write_tick_len(5'd4);
    send_write(4'd11, 16'hC001);
    send_advance(time_after(40));
    drain_reports();
  endtask

  // Mostly fills and short decays with random content, plus idle, behind and noise items.
  task automatic test_random();
    int pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_tick_len(5'd0);
        1: write_tick_len(5'd31);
        default: write_tick_len(ShiftW'($urandom_range(0, 10)));
      endcase
      for (int n = 0; n < 26; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          send_write(IndexW'($urandom_range(0, LoadCount - 1)),
                     ($urandom_range(0, 3) == 0) ? 16'hFFFF : ValueW'($urandom));
        end else if (pick < 80) begin
          send_advance(time_after(($urandom_range(0, 3) == 0) ? $urandom_range(32, 600)
                                                               : $urandom_range(1, 40)));
        end else if (pick < 87) begin
          send_advance(time_after(0));
        end else if (pick < 93) begin
          send_advance(stored_time_model - TimeW'($urandom_range(1, 5000)));
        end else begin
          send_item(1'($urandom_range(0, 1)), $urandom, IndexW'($urandom_range(0, 15)),
                    ValueW'($urandom));
        end
        if ($urandom_range(0, 24) == 0) drain_reports();
      end
      drain_reports();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_writes();
    test_decay_cases();
    test_tick_length();
    test_random();
    drain_reports();
    repeat (20) @(posedge clk);
    $display("Ran %0d counter writes and %0d advances; %0d advances moved the time, %0d cleared.",
             write_count, advance_count, taken_count, clear_count);
    $display("Checked %0d counter reports over %0d tick length settings.",
             reports_checked, cfg_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
